[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QUEUE_DEPTH_DFLT = 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Word slot where the 64-bit length starts (byte 56 of the block)
  localparam logic [3:0] LEN_SLOT_HI = 4'd14;
  localparam logic [3:0] LEN_SLOT_LO = 4'd15;
  localparam logic [5:0] LEN_POS = 6'd56;

  // One 32-bit message word on its way to the compression engine
  typedef struct packed {
    logic [31:0] data;
    logic        last;   // last word of the final block of a message
  } sha_word_t;

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[rtl/core/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into 32-bit words and generates the padding words.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        q_push,
  output sha_word_t   q_entry,
  input  logic        q_full
);

  localparam logic ST_BYTES = 1'b0;
  localparam logic ST_PAD   = 1'b1;

  logic        state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic        first_r, first_nxt;
  logic        final_blk_r, final_blk_nxt;

  logic        accept;
  logic [5:0]  pos_after;
  logic [3:0]  slot;
  logic [63:0] bit_len;

  assign in_stall = (state_r != ST_BYTES) || q_full;
  assign accept   = in_valid && !in_stall;
  assign slot     = pos_r[5:2];
  assign bit_len  = {msg_r[60:0], 3'b000};
  assign pos_after = in_byte_present ? pos_r + 6'd1 : pos_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    msg_nxt       = msg_r;
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    final_blk_nxt = final_blk_r;
    q_push        = 1'b0;
    q_entry       = '0;
    unique case (state_r)
      ST_BYTES: begin
        if (accept) begin
          if (in_byte_present) begin
            acc_nxt = {acc_r[15:0], in_data_byte};
            pos_nxt = pos_after;
            msg_nxt = msg_r + 64'd1;
            if (pos_r[1:0] == 2'd3) begin
              q_push       = 1'b1;
              q_entry.data = {acc_r, in_data_byte};
            end
          end
          if (in_end_of_message) begin
            state_nxt     = ST_PAD;
            first_nxt     = 1'b1;
            // length fits behind the pad byte only if it lands before byte 56
            final_blk_nxt = (pos_after < LEN_POS);
          end
        end
      end
      ST_PAD: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (first_r) begin
            case (pos_r[1:0])
              2'd0:    q_entry.data = {PAD_BYTE, 24'h0};
              2'd1:    q_entry.data = {acc_r[7:0], PAD_BYTE, 16'h0};
              2'd2:    q_entry.data = {acc_r[15:0], PAD_BYTE, 8'h0};
              default: q_entry.data = {acc_r, PAD_BYTE};
            endcase
          end else if (final_blk_r && slot == LEN_SLOT_HI) begin
            q_entry.data = bit_len[63:32];
          end else if (final_blk_r && slot == LEN_SLOT_LO) begin
            q_entry.data = bit_len[31:0];
          end
          q_entry.last = final_blk_r && (slot == LEN_SLOT_LO);
          first_nxt    = 1'b0;
          pos_nxt      = {slot + 4'd1, 2'b00};
          if (slot == LEN_SLOT_LO) begin
            if (final_blk_r) begin
              state_nxt = ST_BYTES;
              pos_nxt   = '0;
              msg_nxt   = '0;
            end else begin
              final_blk_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_BYTES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BYTES;
      pos_r       <= '0;
      msg_r       <= '0;
      first_r     <= 1'b0;
      final_blk_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      msg_r       <= msg_nxt;
      first_r     <= first_nxt;
      final_blk_r <= final_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

[rtl/core/sha_fifo.sv]
// ----------------------------------------------------------------------------
// sha_fifo
// Short word queue between the byte front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_fifo import sha_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sha_word_t push_entry,
  output logic      full,
  input  logic      pop,
  output sha_word_t pop_entry,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  sha_word_t       slot_r [0:DEPTH-1];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[rtl/core/sha_back.sv]
// ----------------------------------------------------------------------------
// sha_back
// Compression engine: loads 16 words, runs 64 rounds, emits the digest.
// ----------------------------------------------------------------------------
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  output logic        q_pop,
  input  sha_word_t   q_entry,
  input  logic        q_empty,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] chain_r [0:7];
  logic [31:0] chain_nxt [0:7];
  logic [31:0] wv_r [0:7];
  logic [31:0] wv_nxt [0:7];
  logic [31:0] w_r [0:15];
  logic [31:0] w_nxt [0:15];
  logic [31:0] dig_r [0:7];
  logic [31:0] dig_nxt [0:7];

  logic [31:0] big0, big1, choose, major, t1, t2, sched_new;

  always_comb begin
    big1   = rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25);
    choose = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    t1     = wv_r[7] + big1 + choose + ROUND_K[cnt_r] + w_r[0];
    big0   = rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22);
    major  = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t2     = big0 + major;
    sched_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
              + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    idx_nxt   = idx_r;
    chain_nxt = chain_r;
    wv_nxt    = wv_r;
    w_nxt     = w_r;
    dig_nxt   = dig_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
          w_nxt[15] = q_entry.data;
          cnt_nxt   = cnt_r + 6'd1;
          if (cnt_r[3:0] == 4'd15) begin
            fin_nxt   = q_entry.last;
            cnt_nxt   = '0;
            wv_nxt    = chain_r;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        wv_nxt[0] = t1 + t2;
        wv_nxt[1] = wv_r[0];
        wv_nxt[2] = wv_r[1];
        wv_nxt[3] = wv_r[2];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[5] = wv_r[4];
        wv_nxt[6] = wv_r[5];
        wv_nxt[7] = wv_r[6];
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = sched_new;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + wv_r[i];
        if (fin_r) begin
          dig_nxt   = chain_nxt;
          chain_nxt = H_INIT;
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          for (int i = 0; i < 7; i++) dig_nxt[i] = dig_r[i+1];
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      idx_r   <= '0;
      chain_r <= H_INIT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r  <= wv_nxt;
    w_r   <= w_nxt;
    dig_r <= dig_nxt;
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = dig_r[0];
  assign out_word_index  = idx_r;
  assign out_final_word  = (idx_r == 3'd7);

endmodule

[rtl/core/sha256_byte_stream_hasher.sv]
// Bytes are taken one per cycle while the word queue has room and no padding
// is being generated. An engine block is 16 pops, 64 rounds and one chaining
// add; the default four-word queue holds only 16 bytes while the rounds run.
// The last item adds 3 to 18 padding words, one or two blocks and eight
// digest words, one a cycle while the output is not stalled.
// Synchronous active-low reset loads the initial hash and empties the queue.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 of a byte stream, digest given as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import sha_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT   // queue words, 2 or more
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  // Front to queue: packed message and padding words
  logic      q_push, q_full;
  sha_word_t q_push_entry;
  // Queue to engine
  logic      q_pop, q_empty;
  sha_word_t q_pop_entry;

  // Front end: accept each transaction, pack bytes, append padding and the
  // bit length once the end of the message is seen. It holds the input
  // channel only while the queue is full or padding is being generated.
  sha_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .q_push            (q_push),
    .q_entry           (q_push_entry),
    .q_full            (q_full)
  );

  // Decouple the byte rate from the round engine.
  sha_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .empty      (q_empty)
  );

  // Back end: one round per cycle; after the final block drive the digest
  // out word by word, then drop back to the initial hash for the next
  // message, whose words may already wait in the queue.
  sha_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_pop           (q_pop),
    .q_entry         (q_pop_entry),
    .q_empty         (q_empty),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word)
  );

endmodule

[tb/sv/tb_sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// Self-checking testbench for the SHA-256 byte stream hasher. A local SHA-256
// model predicts every digest word from the accepted input transactions. The
// checker compares each output transaction with the oldest predicted word.
// Directed messages come first: empty, single byte and extreme bytes. Random
// messages follow, with lengths clustered on the padding boundaries. Both
// sides idle at random, and a long output hold forces the input to stall.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;   // watchdog, far above the slowest run
  localparam int DRAIN_CYCLES = 100;     // settle time after the last digest
  localparam int HOLD_CYCLES = 300;      // long output hold for the fill test
  localparam int MAX_REPORTS = 10;

  // Round constants and initial chaining value, kept locally for the model
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int BLOCK_LEN = 64;
  localparam int LENGTH_OFFSET = 56;

  // One predicted output transaction
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_beat_t;

  // DUT ports, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;

  // Hash model state
  logic [31:0] chain_hash [8];
  logic [7:0]  block_bytes [64];
  int          block_fill;
  logic [63:0] message_len;

  digest_beat_t expected_digest_q [$];

  // Run control and bookkeeping
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          hold_request = 0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          messages_done = 0;
  int          words_checked = 0;
  int          longest_message = 0;
  int          input_stall_cycles = 0;
  int          cycle_count = 0;

  sha256_byte_stream_hasher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_final_word    (out_final_word)
  );

  always #5 clk = ~clk;

  // Watchdog: end a hung run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words still pending",
               cycle_count, expected_digest_q.size());
      $display("sha256_byte_stream_hasher test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // SHA-256 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Return the model to the state of a fresh message
  function automatic void clear_hash_model();
    for (int i = 0; i < 8; i++) chain_hash[i] = SHA_IV[i];
    for (int i = 0; i < BLOCK_LEN; i++) block_bytes[i] = 8'h00;
    block_fill = 0;
    message_len = '0;
  endfunction

  // Fold the 64 buffered bytes into the chaining words
  function automatic void compress_block_bytes();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                  block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
    e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
    for (int i = 0; i < 64; i++) begin
      s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + SHA_K[i] + sched[i];
      s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endfunction

  // Advance the model by one accepted transaction; queue the digest on the
  // end of a message. A byte that comes with the end is hashed first.
  function automatic void predict_digest(input logic [7:0] data, input logic present,
                                         input logic last);
    logic [63:0]  bit_len;
    int           pos;
    digest_beat_t beat;
    if (present) begin
      block_bytes[block_fill] = data;
      block_fill++;
      message_len++;
      if (block_fill == BLOCK_LEN) begin
        compress_block_bytes();
        block_fill = 0;
      end
    end
    if (!last) return;

    bit_len = message_len << 3;
    pos = block_fill;
    block_bytes[pos] = PAD_MARK;
    pos++;
    // No room left for the length: spill into an extra padding block
    if (pos > LENGTH_OFFSET) begin
      for (int i = pos; i < BLOCK_LEN; i++) block_bytes[i] = 8'h00;
      compress_block_bytes();
      pos = 0;
    end
    for (int i = pos; i < LENGTH_OFFSET; i++) block_bytes[i] = 8'h00;
    for (int i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
    compress_block_bytes();

    for (int i = 0; i < 8; i++) begin
      beat.word = chain_hash[i];
      beat.index = i[2:0];
      beat.final_word = (i == 7);
      expected_digest_q = {expected_digest_q, beat};
    end
    messages_done++;
    clear_hash_model();
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted output transaction, then pick next stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    digest_beat_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digest_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected digest word %08h index %0d final %0b",
                   out_digest_word, out_word_index, out_final_word);
      end else begin
        exp = expected_digest_q.pop_front();
        words_checked++;
        if (out_digest_word !== exp.word || out_word_index !== exp.index ||
            out_final_word !== exp.final_word) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                     exp.word, exp.index, exp.final_word,
                     out_digest_word, out_word_index, out_final_word);
        end
      end
    end

    // Pick up a hold request and count it down here
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (sink_idle_en) begin
      out_stall <= ($urandom_range(99) < 33);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one transaction and hold it until accepted; idle cycles before it
  // carry junk payload with valid low.
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    while (src_idle_en && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_byte_present <= 1'($urandom);
      in_end_of_message <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_present <= present;
    in_end_of_message <= last;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    items_sent++;
    predict_digest(data, present, last);
  endtask

  // Send a whole message of random bytes. Close it either on the last byte
  // or with a bare end; an empty message always takes the bare end.
  task automatic send_message(input int len, input bit bare_end, input bit noise);
    for (int i = 0; i < len; i++) begin
      // drop in idle transactions now and then; they must change nothing
      if (noise && $urandom_range(99) < 10) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    if (len > longest_message) longest_message = len;
  endtask

  // Lower valid and pause the sender until every digest has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_digest_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Idle transactions, then the empty message twice in a row
  task automatic test_idle_and_empty();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b1);
    wait_drain();
  endtask

  // Short messages: byte with end, bare end after bytes, extreme byte values
  task automatic test_short_messages();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Random messages, lengths weighted toward the padding boundaries
  task automatic test_random_messages();
    int start_items;
    int len;
    int pick;
    int boundary_len [6] = '{55, 56, 57, 63, 64, 65};
    start_items = items_sent;
    while (items_sent - start_items < 90) begin
      pick = $urandom_range(99);
      if (pick < 50) len = $urandom_range(12, 0);
      else if (pick < 80) len = boundary_len[$urandom_range(5, 0)];
      else len = $urandom_range(80, 13);
      send_message(len, $urandom_range(3, 0) == 0, 1'b1);
    end
    wait_drain();
  endtask

  // Back-to-back traffic on both sides: the largest message that still pads
  // in one block, then a short one right behind it
  task automatic test_burst();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_message(55, 1'b0, 1'b0);
    send_message(9, 1'b1, 1'b0);
    wait_drain();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Hold the output for a long stretch while the next message keeps coming,
  // so the pending digest backs up the engine and the input stalls
  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    send_message(3, 1'b0, 1'b0);
    send_message(20, 1'b0, 1'b0);
    wait_drain();
  endtask

  initial begin
    clear_hash_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_empty();
    test_short_messages();
    test_random_messages();
    test_burst();
    test_output_hold();

    // Let any stray output show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_digest_q.size() != 0) mismatch_count++;

    $display("Covered %0d transactions in %0d messages up to %0d bytes,",
             items_sent, messages_done, longest_message);
    $display("%0d digest words checked, input stalled %0d cycles, %0d mismatches.",
             words_checked, input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sha256_byte_stream_hasher test passed");
    end else begin
      $display("sha256_byte_stream_hasher test failed");
    end
    $finish;
  end

endmodule
